### rtl/core/itp_pkg.sv
// Package of types, constants and the microcode table for the infix-to-postfix converter.
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CLOSE = 2'd1;
    localparam logic [1:0] ERR_OVF   = 2'd2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef logic [3:0] step_t;

    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_OP_TEST  = 4'd1;
    localparam step_t S_OP_CMP   = 4'd2;
    localparam step_t S_OP_POP   = 4'd3;
    localparam step_t S_END_TEST = 4'd4;
    localparam step_t S_END_POP  = 4'd5;
    localparam step_t S_END_MARK = 4'd6;
    localparam step_t S_DIGIT    = 4'd7;
    localparam step_t S_PUSH     = 4'd8;
    localparam step_t S_PUSH_DO  = 4'd9;
    localparam step_t S_OVF      = 4'd10;
    localparam step_t S_CL_TEST  = 4'd11;
    localparam step_t S_CL_CMP   = 4'd12;
    localparam step_t S_CL_POP   = 4'd13;
    localparam step_t S_CL_ERR   = 4'd14;
    localparam step_t S_CL_DROP  = 4'd15;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_EMPTY,
        C_FULL,
        C_TOP_LOWER,
        C_TOP_OPEN
    } cond_t;

    typedef enum logic [2:0] {
        E_NONE,
        E_CHAR,
        E_TOP,
        E_END,
        E_ERR_CLOSE,
        E_ERR_OVF
    } emit_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_POP,
        K_PUSH,
        K_CLEAR
    } cnt_op_t;

    typedef struct packed {
        cond_t   cond;
        step_t   target;
        emit_t   emit;
        cnt_op_t cnt;
    } ctrl_word_t;

    function automatic ctrl_word_t cw(cond_t c, step_t t, emit_t e, cnt_op_t k);
        ctrl_word_t w;
        w.cond   = c;
        w.target = t;
        w.emit   = e;
        w.cnt    = k;
        return w;
    endfunction

    // Each step may emit one beat and change the stack count; the jump is taken
    // when its condition holds, otherwise the step counter moves on by one.
    function automatic ctrl_word_t ucode_rom(step_t s);
        ctrl_word_t w;
        case (s)
            S_OP_TEST:  w = cw(C_EMPTY,     S_PUSH,     E_NONE,      K_HOLD);
            S_OP_CMP:   w = cw(C_TOP_LOWER, S_PUSH,     E_NONE,      K_HOLD);
            S_OP_POP:   w = cw(C_ALWAYS,    S_OP_TEST,  E_TOP,       K_POP);
            S_END_TEST: w = cw(C_EMPTY,     S_END_MARK, E_NONE,      K_HOLD);
            S_END_POP:  w = cw(C_ALWAYS,    S_END_TEST, E_TOP,       K_POP);
            S_END_MARK: w = cw(C_ALWAYS,    S_IDLE,     E_END,       K_HOLD);
            S_DIGIT:    w = cw(C_ALWAYS,    S_IDLE,     E_CHAR,      K_HOLD);
            S_PUSH:     w = cw(C_FULL,      S_OVF,      E_NONE,      K_HOLD);
            S_PUSH_DO:  w = cw(C_ALWAYS,    S_IDLE,     E_NONE,      K_PUSH);
            S_OVF:      w = cw(C_ALWAYS,    S_IDLE,     E_ERR_OVF,   K_CLEAR);
            S_CL_TEST:  w = cw(C_EMPTY,     S_CL_ERR,   E_NONE,      K_HOLD);
            S_CL_CMP:   w = cw(C_TOP_OPEN,  S_CL_DROP,  E_NONE,      K_HOLD);
            S_CL_POP:   w = cw(C_ALWAYS,    S_CL_TEST,  E_TOP,       K_POP);
            S_CL_ERR:   w = cw(C_ALWAYS,    S_IDLE,     E_ERR_CLOSE, K_CLEAR);
            S_CL_DROP:  w = cw(C_ALWAYS,    S_IDLE,     E_NONE,      K_POP);
            default:    w = cw(C_NEVER,     S_IDLE,     E_NONE,      K_HOLD);
        endcase
        return w;
    endfunction

    // Entry point of the program for a newly accepted beat.
    function automatic step_t dispatch(logic kind, logic [7:0] ch);
        step_t s;
        if (kind == KIND_END) begin
            s = S_END_TEST;
        end else if (ch == CH_SPACE) begin
            s = S_IDLE;
        end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
            s = S_DIGIT;
        end else if (ch == CH_OPEN) begin
            s = S_PUSH;
        end else if (ch == CH_CLOSE) begin
            s = S_CL_TEST;
        end else begin
            s = S_OP_TEST;
        end
        return s;
    endfunction

    function automatic logic signed [2:0] prec_of(logic [7:0] ch);
        logic signed [2:0] p;
        case (ch)
            CH_OPEN:           p = 3'sd0;
            CH_PLUS, CH_MINUS: p = 3'sd1;
            CH_STAR, CH_SLASH: p = 3'sd2;
            CH_CARET:          p = 3'sd3;
            default:           p = -3'sd1;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/itp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/infix_to_postfix_converter_unit.sv
// Top level of the infix-to-postfix converter: microcoded sequencer, operator stack and output register.
// Takes one expression character (or an end beat) at a time and emits the postfix stream
// using an operator stack of itp_pkg::STACK_DEPTH entries held in a RAM. The block takes a new
// input beat only when its program has returned to the idle step. A space is dropped at
// dispatch, a digit is emitted, and a '(' is checked against a full stack before it is pushed.
// An operator pops entries until the stack runs empty or it stops at an entry of lower
// precedence, and is then pushed; a ')' pops operators until it drops its '(' or reports an
// unmatched close. An end beat pops every stacked entry and then emits the end mark. In the
// operator and close loops each entry costs a count test step, a compare step (the RAM read
// data is registered) and the step that pops and emits it; the end flush pops without a
// compare. A result beat sits in an output register; while it is not taken, a step that would
// emit another one waits. On m_tdata an error beat (unmatched ')' or stack overflow) carries a
// nonzero error code and empties the stack; m_tlast marks the beat that closes an
// end-of-expression flush.
module infix_to_postfix_converter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in[7:0]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_out[7:0], has_char[8], error_code[10:9], zero[15:11]
    output logic        m_tlast    // end_mark
);

    itp_pkg::step_t                   step_reg, step_next;
    logic [itp_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [itp_pkg::CNT_W-1:0]        count_dec;
    logic [7:0]                       char_reg;
    logic [7:0]                       top_data;
    itp_pkg::ctrl_word_t              ctrl;
    logic                             cond_hit;
    logic                             out_free;
    logic                             stall;
    logic                             push_en;

    logic                             m_valid_reg, m_valid_next;
    logic [7:0]                       out_char_reg;
    logic                             out_has_reg;
    logic                             out_end_reg;
    logic [1:0]                       out_err_reg;

    assign ctrl      = itp_pkg::ucode_rom(step_reg);
    assign count_dec = count_reg - itp_pkg::CNT_W'(1);
    assign out_free  = !m_valid_reg || m_tready;
    assign stall     = (ctrl.emit != itp_pkg::E_NONE) && !out_free;
    assign push_en   = (step_reg != itp_pkg::S_IDLE) && !stall && (ctrl.cnt == itp_pkg::K_PUSH);
    assign s_tready  = (step_reg == itp_pkg::S_IDLE);

    // The read address always follows the top of stack, so the data is ready in the step
    // after the count settles.
    itp_ram #(
        .WIDTH(8),
        .DEPTH(itp_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (push_en),
        .wr_addr (count_reg[itp_pkg::STACK_AW-1:0]),
        .wr_data (char_reg),
        .rd_addr (count_dec[itp_pkg::STACK_AW-1:0]),
        .rd_data (top_data)
    );

    always_comb begin
        case (ctrl.cond)
            itp_pkg::C_ALWAYS:    cond_hit = 1'b1;
            itp_pkg::C_EMPTY:     cond_hit = (count_reg == '0);
            itp_pkg::C_FULL:      cond_hit = (count_reg == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
            itp_pkg::C_TOP_LOWER: cond_hit = (itp_pkg::prec_of(top_data) <
                                              itp_pkg::prec_of(char_reg));
            itp_pkg::C_TOP_OPEN:  cond_hit = (top_data == itp_pkg::CH_OPEN);
            default:              cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (step_reg == itp_pkg::S_IDLE) begin
            if (s_tvalid) begin
                step_next = itp_pkg::dispatch(s_tuser[0], s_tdata);
            end
        end else if (!stall) begin
            step_next = cond_hit ? ctrl.target : step_reg + itp_pkg::step_t'(1);
            case (ctrl.cnt)
                itp_pkg::K_POP:   count_next = count_dec;
                itp_pkg::K_PUSH:  count_next = count_reg + itp_pkg::CNT_W'(1);
                itp_pkg::K_CLEAR: count_next = '0;
                default:          count_next = count_reg;
            endcase
            if (ctrl.emit != itp_pkg::E_NONE) begin
                m_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= itp_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
        end
        if (step_reg != itp_pkg::S_IDLE && !stall && ctrl.emit != itp_pkg::E_NONE) begin
            case (ctrl.emit)
                itp_pkg::E_CHAR: begin
                    out_char_reg <= char_reg;
                    out_has_reg  <= 1'b1;
                    out_end_reg  <= 1'b0;
                    out_err_reg  <= itp_pkg::ERR_NONE;
                end
                itp_pkg::E_TOP: begin
                    out_char_reg <= top_data;
                    out_has_reg  <= 1'b1;
                    out_end_reg  <= 1'b0;
                    out_err_reg  <= itp_pkg::ERR_NONE;
                end
                itp_pkg::E_END: begin
                    out_char_reg <= 8'd0;
                    out_has_reg  <= 1'b0;
                    out_end_reg  <= 1'b1;
                    out_err_reg  <= itp_pkg::ERR_NONE;
                end
                itp_pkg::E_ERR_CLOSE: begin
                    out_char_reg <= 8'd0;
                    out_has_reg  <= 1'b0;
                    out_end_reg  <= 1'b0;
                    out_err_reg  <= itp_pkg::ERR_CLOSE;
                end
                itp_pkg::E_ERR_OVF: begin
                    out_char_reg <= 8'd0;
                    out_has_reg  <= 1'b0;
                    out_end_reg  <= 1'b0;
                    out_err_reg  <= itp_pkg::ERR_OVF;
                end
                default: begin
                    out_char_reg <= 8'd0;
                    out_has_reg  <= 1'b0;
                    out_end_reg  <= 1'b0;
                    out_err_reg  <= itp_pkg::ERR_NONE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_err_reg, out_has_reg, out_char_reg};
    assign m_tlast  = out_end_reg;

endmodule

### tb/itp_postfix_checker.sv
// Checker for the infix-to-postfix converter: predicts the postfix stream and compares each beat.
`timescale 1ns / 100ps
module itp_postfix_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_in[7:0]
    input  logic [0:0]  s_tuser,    // kind[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // char_out[7:0], has_char[8], error_code[10:9], zero[15:11]
    input  logic        m_tlast,    // end_mark
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       end_mark;
        logic [1:0] err;
    } postfix_beat_t;

    postfix_beat_t postfix_q[$];
    logic [7:0]    op_stack [itp_pkg::STACK_DEPTH];
    int            stack_depth = 0;
    int            mismatches  = 0;

    function automatic int rank_of(logic [7:0] ch);
        int r;
        case (ch)
            itp_pkg::CH_OPEN:                    r = 0;
            itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: r = 1;
            itp_pkg::CH_STAR, itp_pkg::CH_SLASH: r = 2;
            itp_pkg::CH_CARET:                   r = 3;
            default:                             r = -1;
        endcase
        return r;
    endfunction

    function automatic void expect_beat(logic [7:0] ch, logic has_ch, logic end_mark,
                                        logic [1:0] err);
        postfix_beat_t b;
        b.ch       = ch;
        b.has_ch   = has_ch;
        b.end_mark = end_mark;
        b.err      = err;
        postfix_q.push_back(b);
    endfunction

    // A push onto a full stack reports overflow and drops the whole stack.
    function automatic void push_op(logic [7:0] ch);
        if (stack_depth < itp_pkg::STACK_DEPTH) begin
            op_stack[stack_depth] = ch;
            stack_depth++;
        end else begin
            stack_depth = 0;
            expect_beat(8'h00, 1'b0, 1'b0, itp_pkg::ERR_OVF);
        end
    endfunction

    function automatic void shunting_step(logic kind, logic [7:0] ch);
        int         r;
        logic [7:0] top;
        bit         found;
        found = 1'b0;
        if (kind == itp_pkg::KIND_END) begin
            while (stack_depth > 0) begin
                stack_depth--;
                expect_beat(op_stack[stack_depth], 1'b1, 1'b0, itp_pkg::ERR_NONE);
            end
            expect_beat(8'h00, 1'b0, 1'b1, itp_pkg::ERR_NONE);
        end else if (ch >= itp_pkg::CH_ZERO && ch <= itp_pkg::CH_NINE) begin
            expect_beat(ch, 1'b1, 1'b0, itp_pkg::ERR_NONE);
        end else if (ch == itp_pkg::CH_OPEN) begin
            push_op(ch);
        end else if (ch == itp_pkg::CH_CLOSE) begin
            while (stack_depth > 0 && !found) begin
                stack_depth--;
                top = op_stack[stack_depth];
                if (top == itp_pkg::CH_OPEN) begin
                    found = 1'b1;
                end else begin
                    expect_beat(top, 1'b1, 1'b0, itp_pkg::ERR_NONE);
                end
            end
            if (!found) begin
                expect_beat(8'h00, 1'b0, 1'b0, itp_pkg::ERR_CLOSE);
            end
        end else if (ch != itp_pkg::CH_SPACE) begin
            r = rank_of(ch);
            while (stack_depth > 0 && rank_of(op_stack[stack_depth - 1]) >= r) begin
                stack_depth--;
                expect_beat(op_stack[stack_depth], 1'b1, 1'b0, itp_pkg::ERR_NONE);
            end
            push_op(ch);
        end
    endfunction

    always @(posedge aclk) begin
        postfix_beat_t want;
        postfix_beat_t got;
        got.ch       = m_tdata[7:0];
        got.has_ch   = m_tdata[8];
        got.err      = m_tdata[10:9];
        got.end_mark = m_tlast;
        if (!aresetn) begin
            stack_depth = 0;
            postfix_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                shunting_step(s_tuser[0], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (postfix_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result beat: char %h has %b end %b err %0d",
                                 $realtime, got.ch, got.has_ch, got.end_mark, got.err);
                    end
                end else begin
                    want = postfix_q.pop_front();
                    if (got !== want || m_tdata[15:11] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch: expected char %h has %b end %b err %0d",
                                     $realtime, want.ch, want.has_ch, want.end_mark, want.err);
                            $display("%0t:   got char %h has %b end %b err %0d pad %h",
                                     $realtime, got.ch, got.has_ch, got.end_mark, got.err,
                                     m_tdata[15:11]);
                        end
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= postfix_q.size();
    end

endmodule

### tb/tb_infix_to_postfix_converter_unit.sv
// Top of the infix-to-postfix converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_infix_to_postfix_converter_unit;

    localparam int ITEM_TARGET  = 470;
    localparam int QUIET_FROM   = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 150;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int         fail_count;
    int         pending;
    int         chars_sent  = 0;
    int         idle_cycles = 0;
    int         rx_hold     = 0;
    bit         quiet       = 1'b0;
    logic [7:0] text_q[$];

    infix_to_postfix_converter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    itp_postfix_checker u_postfix_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side stalls in bursts that start at random while the bench is not quiet.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_hold  <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic kind, input logic [7:0] ch);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == itp_pkg::KIND_END || ch != itp_pkg::CH_SPACE) begin
            chars_sent++;
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_beat(itp_pkg::KIND_CHAR, txt[i]);
        end
    endtask

    task automatic send_queued();
        while (text_q.size() > 0) begin
            send_beat(itp_pkg::KIND_CHAR, text_q.pop_front());
        end
    endtask

    // Holds the input side off until the checker has seen every expected beat.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_op();
        logic [7:0] op;
        case ($urandom_range(0, 4))
            0:       op = itp_pkg::CH_PLUS;
            1:       op = itp_pkg::CH_MINUS;
            2:       op = itp_pkg::CH_STAR;
            3:       op = itp_pkg::CH_SLASH;
            default: op = itp_pkg::CH_CARET;
        endcase
        return op;
    endfunction

    // Appends an expression to text_q; letters fill some operand places but convert as operators.
    function automatic void gen_expr(int level);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) begin
                text_q.push_back(pick_op());
            end
            if (level > 0 && $urandom_range(0, 3) == 0) begin
                text_q.push_back(itp_pkg::CH_OPEN);
                gen_expr(level - 1);
                text_q.push_back(itp_pkg::CH_CLOSE);
            end else if ($urandom_range(0, 9) == 0) begin
                text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
            end else begin
                text_q.push_back(itp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 5) == 0) begin
                text_q.push_back(itp_pkg::CH_SPACE);
            end
        end
    endfunction

    initial begin
        int  depth;
        bit  paused;
        paused = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("1 +2*3");
        send_beat(itp_pkg::KIND_END, 8'h00);
        send_text("(4-5)/6^7");
        send_beat(itp_pkg::KIND_END, 8'h00);
        // A close that pops an operator and then runs dry, then one on an empty stack.
        send_text("+)");
        send_text(")");
        send_beat(itp_pkg::KIND_CHAR, 8'hFF);
        send_beat(itp_pkg::KIND_CHAR, 8'h00);
        send_text("(a");
        send_beat(itp_pkg::KIND_END, 8'hFF);
        // The flush emits the leftover open parenthesis.
        send_text("(9");
        send_beat(itp_pkg::KIND_END, 8'h00);

        // Overflow by an open parenthesis, then by an operator on a full stack.
        repeat (itp_pkg::STACK_DEPTH + 1) send_beat(itp_pkg::KIND_CHAR, itp_pkg::CH_OPEN);
        send_beat(itp_pkg::KIND_END, 8'h00);
        repeat (itp_pkg::STACK_DEPTH) send_beat(itp_pkg::KIND_CHAR, itp_pkg::CH_OPEN);
        send_beat(itp_pkg::KIND_CHAR, itp_pkg::CH_STAR);
        send_beat(itp_pkg::KIND_END, 8'h00);
        wait_drained();

        while (chars_sent < ITEM_TARGET) begin
            if (chars_sent >= QUIET_FROM) begin
                quiet <= 1'b1;
            end
            if (!paused && chars_sent >= ITEM_TARGET / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    end
                end
                1: begin
                    depth = $urandom_range(28, 36);
                    repeat (depth) text_q.push_back(itp_pkg::CH_OPEN);
                    gen_expr(1);
                    repeat ($urandom_range(0, 4)) text_q.push_back(itp_pkg::CH_CLOSE);
                    send_queued();
                    send_beat(itp_pkg::KIND_END, 8'($urandom_range(0, 255)));
                end
                2: begin
                    gen_expr(2);
                    text_q.push_back(itp_pkg::CH_CLOSE);
                    gen_expr(1);
                    send_queued();
                    send_beat(itp_pkg::KIND_END, 8'($urandom_range(0, 255)));
                end
                default: begin
                    gen_expr(3);
                    send_queued();
                    send_beat(itp_pkg::KIND_END, 8'($urandom_range(0, 255)));
                end
            endcase
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### infix_to_postfix_converter_unit.f
rtl/core/itp_pkg.sv
rtl/core/itp_ram.sv
rtl/core/infix_to_postfix_converter_unit.sv
tb/itp_postfix_checker.sv
tb/tb_infix_to_postfix_converter_unit.sv
